// ===== src/ccsd_pkg.sv =====
// shared types and constants for the capped cone signed distance core
// no dependencies; imported by every module in src
package ccsd_pkg;

  // fraction bits of the fixed-point format (sets the reset geometry)
  localparam int FRAC_BITS = 16;

  // square root unit: radicand width and root width (one root bit per stage)
  localparam int RAD_W  = 68;
  localparam int ROOT_W = 34;

  // divider: numerator magnitude width and quotient bits (one bit per stage)
  localparam int NUM_W = 67;
  localparam int Q_W   = 34;

  // register indexes of the configuration port
  localparam logic [2:0] REG_RADIUS_LOW  = 3'd0;
  localparam logic [2:0] REG_PLANE_LOW   = 3'd1;
  localparam logic [2:0] REG_RADIUS_HIGH = 3'd2;
  localparam logic [2:0] REG_PLANE_HIGH  = 3'd3;
  localparam logic [2:0] REG_INVERT_SIGN = 3'd4;

  // saturation limits of the distance
  localparam logic [31:0] DIST_MAX = 32'h7fff_ffff;
  localparam logic [31:0] DIST_MIN = 32'h8000_0000;

  // per-request data carried alongside the arithmetic units
  typedef struct packed {
    logic               bad;
    logic signed [31:0] z;
  } ccsd_side_t;

endpackage

// ===== src/capped_cone_signed_distance_core.sv =====
// capped cone signed distance core: throughput one request per cycle while the
// output is not stalled; the 34-stage square root and the 34-stage divider,
// one result bit per stage each, set the depth
// synchronous reset clears the valid bits and loads the reset geometry; the
// constant pipeline in ccsd_geom settles after a reset or write
// depends on ccsd_pkg, ccsd_geom, ccsd_isqrt, ccsd_div
module capped_cone_signed_distance_core import ccsd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] distance,
  output logic               saturated,
  output logic               bad_geometry,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // configuration registers
  logic [30:0]        radius_low;
  logic signed [31:0] plane_low;
  logic [30:0]        radius_high;
  logic signed [31:0] plane_high;
  logic               invert_sign;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_low  <= 31'(1) << FRAC_BITS;
      plane_low   <= -(32'sd1 <<< FRAC_BITS);
      radius_high <= '0;
      plane_high  <= 32'sd1 <<< FRAC_BITS;
      invert_sign <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS_LOW:  radius_low  <= cfg_data[30:0];
        REG_PLANE_LOW:   plane_low   <= $signed(cfg_data);
        REG_RADIUS_HIGH: radius_high <= cfg_data[30:0];
        REG_PLANE_HIGH:  plane_high  <= $signed(cfg_data);
        REG_INVERT_SIGN: invert_sign <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // derived cone constants
  logic signed [32:0] dz;
  logic signed [31:0] dr;
  logic signed [63:0] k_term;
  logic [ROOT_W-1:0]  len;

  ccsd_geom u_geom (
    .clk         (clk),
    .rst         (rst),
    .radius_low  (radius_low),
    .plane_low   (plane_low),
    .radius_high (radius_high),
    .plane_high  (plane_high),
    .dz          (dz),
    .dr          (dr),
    .k_term      (k_term),
    .len         (len)
  );

  // pipeline advance: output register free or being taken
  logic adv;
  assign adv      = ~out_valid | out_ready;

  // input stage fills whenever it is empty or the pipeline advances
  logic               v0;
  logic signed [31:0] x0, y0, z0;
  assign in_ready = adv | ~v0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (in_ready) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      x0 <= point_x;
      y0 <= point_y;
      z0 <= point_z;
    end
  end

  // squares of x and y, geometry check
  logic               v1;
  logic signed [63:0] sqx, sqy;
  ccsd_side_t         side1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx       <= x0 * x0;
      sqy       <= y0 * y0;
      side1.z   <= z0;
      side1.bad <= plane_high <= plane_low;
    end
  end

  // radial distance
  logic [RAD_W-1:0]  rho_rad;
  logic              rv;
  logic [ROOT_W-1:0] rho;
  ccsd_side_t        rside;

  assign rho_rad = {4'b0, sqx[63:0] + sqy[63:0]};

  ccsd_isqrt u_rho_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v1),
    .radicand  (rho_rad),
    .in_side   (side1),
    .out_valid (rv),
    .root      (rho),
    .out_side  (rside)
  );

  // numerator products
  logic               vm;
  logic signed [65:0] p1;
  logic signed [63:0] p2;
  ccsd_side_t         mside;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (adv) begin
      vm <= rv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1    <= dz * $signed({1'b0, rho[31:0]});
      p2    <= dr * rside.z;
      mside <= rside;
    end
  end

  // numerator sum
  logic               vn;
  logic signed [66:0] num;
  ccsd_side_t         nside;
  logic               num_neg;
  logic [NUM_W-1:0]   num_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      vn <= 1'b0;
    end else if (adv) begin
      vn <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num   <= 67'(p1) + 67'(p2) + 67'(k_term);
      nside <= mside;
    end
  end

  assign num_neg = num[66];
  assign num_mag = num_neg ? NUM_W'(-num) : NUM_W'(num);

  // side term quotient
  logic           dv, d_ovf, d_neg;
  logic [Q_W-1:0] d_q;
  ccsd_side_t     dside;

  ccsd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vn),
    .num_mag   (num_mag),
    .in_neg    (num_neg),
    .divisor   (len),
    .in_side   (nside),
    .out_valid (dv),
    .quot      (d_q),
    .out_ovf   (d_ovf),
    .out_neg   (d_neg),
    .out_side  (dside)
  );

  // slab term, max, sign and saturation
  logic [34:0]        side_mag;
  logic signed [35:0] side_s;
  logic signed [33:0] slab_a, slab_b, slab;
  logic signed [35:0] sd;
  logic signed [36:0] sdi;
  logic               sat_hi, sat_lo;
  logic [31:0]        distance_next;
  logic               saturated_next;

  always_comb begin
    side_mag = d_ovf ? 35'(1) << Q_W : {1'b0, d_q};
    side_s   = d_neg ? -$signed({1'b0, side_mag}) : $signed({1'b0, side_mag});
    slab_a   = 34'(dside.z) - 34'(plane_high);
    slab_b   = 34'(plane_low) - 34'(dside.z);
    slab     = (slab_a > slab_b) ? slab_a : slab_b;
    sd       = (side_s > 36'(slab)) ? side_s : 36'(slab);
    sdi      = invert_sign ? -37'(sd) : 37'(sd);
    sat_hi   = sdi > 37'sd2147483647;
    sat_lo   = sdi < -37'sd2147483648;
    priority if (dside.bad) begin
      distance_next  = '0;
      saturated_next = 1'b0;
    end else if (sat_hi) begin
      distance_next  = DIST_MAX;
      saturated_next = 1'b1;
    end else if (sat_lo) begin
      distance_next  = DIST_MIN;
      saturated_next = 1'b1;
    end else begin
      distance_next  = sdi[31:0];
      saturated_next = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      distance     <= $signed(distance_next);
      saturated    <= saturated_next;
      bad_geometry <= dside.bad;
    end
  end

  // checks
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_geometry |-> distance == 32'sd0 && !saturated)
    else $error("bad geometry result not zero");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> distance == $signed(DIST_MAX) || distance == $signed(DIST_MIN))
    else $error("saturated result not at a limit");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst) !v0 |-> in_ready)
    else $error("empty input stage refuses a request");

endmodule

// ===== src/ccsd_isqrt.sv =====
// pipelined floor square root, one root bit resolved per stage
// depends on ccsd_pkg (widths, sideband type)
module ccsd_isqrt import ccsd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  radicand,
  input  ccsd_side_t        in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output ccsd_side_t        out_side
);

  logic [RAD_W-1:0] op   [0:ROOT_W-1];
  logic [RAD_W-1:0] res  [0:ROOT_W];
  ccsd_side_t       side [0:ROOT_W];
  logic [ROOT_W:0]  vld;

  // valid bits shift with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ROOT_W-1:0], in_valid};
    end
  end

  // entry register
  always_ff @(posedge clk) begin
    if (en) begin
      op[0]   <= radicand;
      res[0]  <= '0;
      side[0] <= in_side;
    end
  end

  // digit-by-digit stages
  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam logic [RAD_W-1:0] ONE = RAD_W'(1) << (2 * (ROOT_W - 1 - k));
    logic [RAD_W-1:0] trial;
    logic             fit;

    assign trial = res[k] + ONE;
    assign fit   = op[k] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        res[k+1]  <= fit ? (res[k] >> 1) + ONE : res[k] >> 1;
        side[k+1] <= side[k];
      end
    end

    if (k < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          op[k+1] <= fit ? op[k] - trial : op[k];
        end
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = res[ROOT_W][ROOT_W-1:0];
  assign out_side  = side[ROOT_W];

endmodule

// ===== src/ccsd_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// depends on ccsd_pkg (widths, sideband type)
module ccsd_div import ccsd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num_mag,
  input  logic              in_neg,
  input  logic [ROOT_W-1:0] divisor,
  input  ccsd_side_t        in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    quot,
  output logic              out_ovf,
  output logic              out_neg,
  output ccsd_side_t        out_side
);

  logic [RAD_W-1:0] rem  [0:Q_W-1];
  logic [Q_W-1:0]   q    [0:Q_W];
  logic             ovf  [0:Q_W];
  logic             neg  [0:Q_W];
  ccsd_side_t       side [0:Q_W];
  logic [Q_W:0]     vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Q_W-1:0], in_valid};
    end
  end

  // entry: quotient beyond the bit range is flagged up front
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= {1'b0, num_mag};
      q[0]    <= '0;
      ovf[0]  <= {1'b0, num_mag} >= {divisor, {Q_W{1'b0}}};
      neg[0]  <= in_neg;
      side[0] <= in_side;
    end
  end

  // one compare and subtract per stage
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int SH = Q_W - 1 - k;
    logic [RAD_W-1:0] dsh;
    logic             fit;

    assign dsh = RAD_W'(divisor) << SH;
    assign fit = rem[k] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        q[k+1]    <= q[k] | (fit ? Q_W'(1) << SH : '0);
        ovf[k+1]  <= ovf[k];
        neg[k+1]  <= neg[k];
        side[k+1] <= side[k];
      end
    end

    if (k < Q_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= fit ? rem[k] - dsh : rem[k];
        end
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign quot      = q[Q_W];
  assign out_ovf   = ovf[Q_W];
  assign out_neg   = neg[Q_W];
  assign out_side  = side[Q_W];

endmodule

// ===== src/ccsd_geom.sv =====
// cone constants derived from the configuration registers, free running
// depends on ccsd_pkg and ccsd_isqrt (slant length root)
module ccsd_geom import ccsd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [30:0]          radius_low,
  input  logic signed [31:0]   plane_low,
  input  logic [30:0]          radius_high,
  input  logic signed [31:0]   plane_high,
  output logic signed [32:0]   dz,
  output logic signed [31:0]   dr,
  output logic signed [63:0]   k_term,
  output logic [ROOT_W-1:0]    len
);

  logic signed [63:0] prod_lo;
  logic signed [63:0] prod_hi;
  logic signed [65:0] dz_sq;
  logic signed [63:0] dr_sq;
  logic [RAD_W-1:0]   len_rad;

  // plane and radius differences, constant term products
  always_ff @(posedge clk) begin
    dz      <= $signed({plane_high[31], plane_high}) - $signed({plane_low[31], plane_low});
    dr      <= $signed({1'b0, radius_low}) - $signed({1'b0, radius_high});
    prod_lo <= plane_low * $signed({1'b0, radius_high});
    prod_hi <= plane_high * $signed({1'b0, radius_low});
  end

  // squares and constant term
  always_ff @(posedge clk) begin
    dz_sq  <= dz * dz;
    dr_sq  <= dr * dr;
    k_term <= prod_lo - prod_hi;
  end

  // sum of squares for the slant length
  always_ff @(posedge clk) begin
    len_rad <= {2'b0, dz_sq[65:0]} + {4'b0, dr_sq[63:0]};
  end

  ccsd_isqrt u_len_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (1'b1),
    .in_valid  (1'b1),
    .radicand  (len_rad),
    .in_side   ('0),
    .out_valid (),
    .root      (len),
    .out_side  ()
  );

endmodule

// ===== verif/capped_cone_signed_distance_core_tb.sv =====
// testbench for the capped cone signed distance core: directed table plus random
// points under several geometries, checked against a behavioral distance predictor
// depends on ccsd_pkg and capped_cone_signed_distance_core
`timescale 1ns / 100ps

module capped_cone_signed_distance_core_tb;
  import ccsd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] distance;
  logic saturated, bad_geometry;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_RADIUS_LOW;
  logic [31:0] cfg_data = '0;

  typedef struct {
    logic signed [31:0] value;
    logic sat;
    logic bad;
  } dist_result_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic chk;
    dist_result_t res;
  } point_row_t;

  // predictor's copy of the geometry registers
  logic [30:0] geo_r_low, geo_r_high;
  logic signed [31:0] geo_z_low, geo_z_high;
  logic geo_invert;

  dist_result_t expected_dist_q[$];
  int fail_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit finished = 0;

  always #6 clk = ~clk;

  capped_cone_signed_distance_core DUT (.*);

  // floor square root of a nonnegative value below 2^68
  function automatic logic [33:0] floor_sqrt(input logic [67:0] v);
    logic [67:0] rem;
    logic [33:0] root;
    logic [69:0] trial;
    rem = v;
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      trial = ({36'd0, root} << (b + 1)) + (70'd1 << (2 * b));
      if (trial <= {2'b0, rem}) begin
        rem = rem - trial[67:0];
        root[b] = 1'b1;
      end
    end
    return root;
  endfunction

  function automatic dist_result_t cone_distance(input logic signed [31:0] x,
                                                  input logic signed [31:0] y,
                                                  input logic signed [31:0] z);
    dist_result_t r;
    logic signed [63:0] dz, dr, slab, side, sd;
    logic [67:0] rad;
    logic [33:0] rho, len;
    logic signed [127:0] num;
    logic [127:0] mag, quo;
    r.value = '0;
    r.sat = 1'b0;
    r.bad = 1'b0;
    if (geo_z_high <= geo_z_low) begin
      r.bad = 1'b1;
      return r;
    end
    dz = 64'(geo_z_high) - 64'(geo_z_low);
    dr = $signed({33'd0, geo_r_low}) - $signed({33'd0, geo_r_high});
    rad = 68'(128'(64'(x) * 64'(x)) + 128'(64'(y) * 64'(y)));
    rho = floor_sqrt(rad);
    rad = 68'($signed(128'(dz)) * $signed(128'(dz)) + $signed(128'(dr)) * $signed(128'(dr)));
    len = floor_sqrt(rad);
    num = $signed(128'(dz)) * $signed({94'd0, rho}) + $signed(128'(dr)) * $signed(128'(z))
        - $signed(128'(geo_z_high)) * $signed({97'd0, geo_r_low})
        + $signed(128'(geo_z_low)) * $signed({97'd0, geo_r_high});
    mag = num[127] ? 128'(-num) : 128'(num);
    quo = mag / {94'd0, len};
    side = (quo > (128'd1 << 40)) ? (64'sd1 <<< 40) : $signed(quo[63:0]);
    if (num[127]) side = -side;
    slab = 64'(z) - 64'(geo_z_high);
    if (64'(geo_z_low) - 64'(z) > slab) slab = 64'(geo_z_low) - 64'(z);
    sd = side > slab ? side : slab;
    if (geo_invert) sd = -sd;
    if (sd > 64'sd2147483647) begin
      sd = 64'sd2147483647;
      r.sat = 1'b1;
    end else if (sd < -64'sd2147483648) begin
      sd = -64'sd2147483648;
      r.sat = 1'b1;
    end
    r.value = sd[31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("error: %s got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // register write while idle, mirrored into the predictor
  task automatic write_geometry(input logic [2:0] idx, input logic [31:0] val);
    in_valid <= 1'b0;
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_RADIUS_LOW: geo_r_low = val[30:0];
      REG_PLANE_LOW: geo_z_low = val;
      REG_RADIUS_HIGH: geo_r_high = val[30:0];
      REG_PLANE_HIGH: geo_z_high = val;
      REG_INVERT_SIGN: geo_invert = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(input logic [31:0] rl, input logic [31:0] zl,
                              input logic [31:0] rh, input logic [31:0] zh,
                              input logic inv);
    write_geometry(REG_RADIUS_LOW, rl);
    write_geometry(REG_PLANE_LOW, zl);
    write_geometry(REG_RADIUS_HIGH, rh);
    write_geometry(REG_PLANE_HIGH, zh);
    write_geometry(REG_INVERT_SIGN, {31'd0, inv});
  endtask

  // drain all outstanding distances, then let the pipeline settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_dist_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one request: optional idle gap, then hold valid until accepted
  task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_dist_q.push_back(cone_distance(x, y, z));
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $signed($urandom_range(8 << 16)) - (4 << 16);
      2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $signed($urandom_range(1 << 20)) - (1 << 19);
    endcase
  endfunction

  // receiver stalls and output checking
  always @(negedge clk) out_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_dist_q.size() == 0) begin
        report_mismatch("unexpected distance", distance, 32'd0);
      end else begin
        dist_result_t e;
        e = expected_dist_q.pop_front();
        if (distance !== e.value) report_mismatch("distance", distance, e.value);
        if (saturated !== e.sat)
          report_mismatch("saturated", {31'd0, saturated}, {31'd0, e.sat});
        if (bad_geometry !== e.bad)
          report_mismatch("bad_geometry", {31'd0, bad_geometry}, {31'd0, e.bad});
      end
    end
  end

  // watchdog on cycles with no accepted request either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst || cfg_we) idle_cycles <= 0;
    else if (expected_dist_q.size() != 0 || (in_valid && !finished)) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  point_row_t dir_rows[$];

  initial begin
    point_row_t row;
    dist_result_t r;
    geo_r_low = 31'h1_0000;
    geo_z_low = -32'sh1_0000;
    geo_r_high = '0;
    geo_z_high = 32'sh1_0000;
    geo_invert = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);

    // directed rows on the reset cone; at the origin the side term wins over the slab
    row = '{x: 0, y: 0, z: 0, chk: 1, res: '{value: -32'sd29308, sat: 0, bad: 0}};
    dir_rows.push_back(row);
    row = '{x: 32'h7fff_ffff, y: 32'h7fff_ffff, z: 32'h7fff_ffff, chk: 1,
            res: '{value: 32'h7fff_ffff, sat: 1, bad: 0}};
    dir_rows.push_back(row);
    foreach (dir_rows[i]) begin
      r = cone_distance(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z);
      if (r.value !== dir_rows[i].res.value || r.sat !== dir_rows[i].res.sat)
        report_mismatch("table row", r.value, dir_rows[i].res.value);
    end
    dir_rows.push_back('{x: 32'h8000_0000, y: 32'h8000_0000, z: 32'h8000_0000, chk: 0,
                        res: '{value: 0, sat: 0, bad: 0}});
    dir_rows.push_back('{x: 32'h8000_0000, y: 0, z: 32'h7fff_ffff, chk: 0,
                        res: '{value: 0, sat: 0, bad: 0}});
    dir_rows.push_back('{x: 1, y: -1, z: -32'sh1_0000, chk: 0, res: '{value: 0, sat: 0, bad: 0}});
    dir_rows.push_back('{x: 32'sh1_0000, y: 0, z: 32'sh1_0000, chk: 0,
                        res: '{value: 0, sat: 0, bad: 0}});
    dir_rows.push_back('{x: -1, y: -1, z: -1, chk: 0, res: '{value: 0, sat: 0, bad: 0}});
    foreach (dir_rows[i]) send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z);
    wait_drained();

    // inverted extreme: negating the minimum saturates
    set_geometry(32'h7fff_ffff, 32'h8000_0000, 0, 32'h7fff_ffff, 1);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_point(0, 0, 32'h7fff_ffff);
    send_point(0, 0, 0);
    wait_drained();
    // cylinder, upper bits of wide radius writes ignored
    set_geometry(32'hffff_ffff, -32'sh2_0000, 32'hffff_ffff, 32'sh2_0000, 0);
    send_point(0, 0, 0);
    send_point(32'h7fff_ffff, 0, 0);
    wait_drained();
    // bad geometry: equal planes, then reversed
    set_geometry(32'h1_0000, 32'sh1_0000, 32'h2_0000, 32'sh1_0000, 0);
    send_point(5, 6, 7);
    wait_drained();
    write_geometry(REG_PLANE_HIGH, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    wait_drained();

    // random phases with different geometries and idling mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 56; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 56; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if (ph == 7) set_geometry($urandom, $urandom, $urandom, $urandom, 1'($urandom));
      else set_geometry($urandom_range(1 << 19), -$urandom_range(1 << 19),
                        $urandom_range(ph) == 0 ? 0 : $urandom_range(1 << 19),
                        $urandom_range(1 << 19) + 1, ph[0]);
      for (int n = 0; n < 160; n++) begin
        send_point(rand_coord(), rand_coord(), rand_coord());
        // hold off once mid-phase until everything has come back
        if (ph == 3 && n == 80) begin
          in_valid <= 1'b0;
          while (expected_dist_q.size() != 0) @(negedge clk);
        end
      end
      wait_drained();
    end

    finished = 1;
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
